FILE: src/ptag_pkg.sv
// ----------------------------------------------------------------------------
// ptag_pkg
// Shared constants, types and helpers for the pencil transpose address
// generator: field widths, register map, mode codes and pipeline stage words.
// ----------------------------------------------------------------------------
package ptag_pkg;

  // Element address width and per-axis size exponent
  localparam int ADDR_BITS = 24;
  localparam int DIM_BITS  = 12;

  // One axis size 1 .. 2^DIM_BITS, quotient digits, products of sizes
  localparam int DW = DIM_BITS + 1;
  localparam int QW = DIM_BITS;
  localparam int PW = 2 * DW;
  localparam int TW = 3 * DW;

  // Register field widths and APB geometry
  localparam int CFG_W   = 13;
  localparam int MODE_W  = 2;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  // Division datapath widths (remainder against shifted divisor)
  localparam int CW1 = ADDR_BITS + PW + QW;
  localparam int CW2 = ADDR_BITS + DW + QW;
  // Width of the index / total compare
  localparam int EW  = ADDR_BITS + TW;

  // Pipeline geometry: input, hold, range check, two restoring dividers,
  // then multiply and add stages
  localparam int NP = 3 + 2 * QW;
  localparam int NS = NP + 2;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [DW-1:0]        dim_t;
  typedef logic [QW-1:0]        quo_t;
  typedef logic [CFG_W-1:0]     grid_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_Z2X = 2'd0,
    MODE_X2Y = 2'd1,
    MODE_Y2Z = 2'd2,
    MODE_X2Z = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_GRID_X = 2'd0,
    REG_GRID_Y = 2'd1,
    REG_GRID_Z = 2'd2,
    REG_MODE   = 2'd3
  } reg_idx_t;

  // Word carried through the range check and divider stages
  typedef struct packed {
    addr_t idx;
    addr_t rem;
    quo_t  qi;
    quo_t  qj;
    logic  last;
    logic  oor;
  } stage_t;

  // Word after the multiply stage
  typedef struct packed {
    addr_t pa;
    addr_t pb;
    quo_t  c;
    addr_t idx;
    logic  last;
    logic  oor;
  } prod_t;

  // Finished result word
  typedef struct packed {
    addr_t rd;
    addr_t wr;
    logic  last;
    logic  oor;
  } res_t;

  // Zero reads as one, anything above 2^DIM_BITS saturates
  function automatic dim_t clamp_dim(grid_t v);
    if (v == '0) begin
      return dim_t'(1);
    end else if (32'(v) > (32'd1 << DIM_BITS)) begin
      return dim_t'(32'd1 << DIM_BITS);
    end else begin
      return dim_t'(v);
    end
  endfunction

endpackage

FILE: src/ptag_if.sv
// ----------------------------------------------------------------------------
// ptag_if
// Valid/ready channels for the address generator: element index in,
// address pair and flags out.
// ----------------------------------------------------------------------------
interface ptag_in_if;
  import ptag_pkg::*;

  logic  valid;
  logic  ready;
  addr_t element_index;

  modport source (output valid, output element_index, input ready);
  modport sink   (input valid, input element_index, output ready);
endinterface

interface ptag_out_if;
  import ptag_pkg::*;

  logic  valid;
  logic  ready;
  addr_t read_address;
  addr_t write_address;
  logic  last_element;
  logic  out_of_range;

  modport source (output valid, output read_address, output write_address,
                  output last_element, output out_of_range, input ready);
  modport sink   (input valid, input read_address, input write_address,
                  input last_element, input out_of_range, output ready);
endinterface

FILE: src/pencil_transpose_address_gen_top.sv
// ----------------------------------------------------------------------------
// pencil_transpose_address_gen_top
// Splits a linear element index into three grid coordinates with two
// pipelined restoring dividers and recombines them into read/write addresses.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output skid is not full; each divider
//   resolves one quotient bit per stage, which sets the pipeline depth.
// A two-word output skid keeps the input open while a result waits.
// Reset: synchronous, active low; clears the grid registers to 1, the mode to
//   z-to-x and all valid state. No clearing pass.
module pencil_transpose_address_gen_top (
  input  logic                         clk,
  input  logic                         rst_n,
  ptag_in_if.sink                      in_ch,
  ptag_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ptag_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [ptag_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ptag_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import ptag_pkg::*;

  // Configuration registers
  grid_t    grid_x_r, grid_y_r, grid_z_r;
  mode_t    mode_r;
  logic     cfg_we;
  reg_idx_t cfg_idx;

  // Sizes derived from the configuration, two register levels
  dim_t           dx_r, dy_r, dz_r;
  logic [PW-1:0]  xy_r, yz_r, plane_r;
  logic [TW-1:0]  total_r;
  dim_t           row_r;

  // Pipeline
  logic [NS-1:0]  vld_r;
  logic           en;
  stage_t         pipe_r   [NP];
  stage_t         pipe_nxt [NP];
  stage_t         s0_nxt, s2_nxt;
  prod_t          mul_r, mul_nxt;
  res_t           res_r, res_nxt;

  // Output skid
  res_t           head_r, head_nxt, skid_r, skid_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  // ---------------------------------------------------------------- APB port
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_x_r <= grid_t'(1);
      grid_y_r <= grid_t'(1);
      grid_z_r <= grid_t'(1);
      mode_r   <= MODE_Z2X;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GRID_X: grid_x_r <= cfg_pwdata[CFG_W-1:0];
        REG_GRID_Y: grid_y_r <= cfg_pwdata[CFG_W-1:0];
        REG_GRID_Z: grid_z_r <= cfg_pwdata[CFG_W-1:0];
        REG_MODE:   mode_r   <= mode_t'(cfg_pwdata[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GRID_X: cfg_prdata = DATA_W'(grid_x_r);
      REG_GRID_Y: cfg_prdata = DATA_W'(grid_y_r);
      REG_GRID_Z: cfg_prdata = DATA_W'(grid_z_r);
      REG_MODE:   cfg_prdata = DATA_W'(mode_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------- derived sizes
  // level 1: clamped sizes and pair products
  always_ff @(posedge clk) begin
    dx_r <= clamp_dim(grid_x_r);
    dy_r <= clamp_dim(grid_y_r);
    dz_r <= clamp_dim(grid_z_r);
    xy_r <= PW'(clamp_dim(grid_x_r)) * PW'(clamp_dim(grid_y_r));
    yz_r <= PW'(clamp_dim(grid_y_r)) * PW'(clamp_dim(grid_z_r));
  end

  // level 2: grid total, plane and row for the current mode
  always_ff @(posedge clk) begin
    total_r <= TW'(xy_r) * TW'(dz_r);
    case (mode_r)
      MODE_X2Y: begin
        plane_r <= yz_r;
        row_r   <= dy_r;
      end
      MODE_Y2Z: begin
        plane_r <= yz_r;
        row_r   <= dz_r;
      end
      default: begin
        plane_r <= xy_r;
        row_r   <= dx_r;
      end
    endcase
  end

  // ------------------------------------------------------- pipeline control
  // the whole pipe moves unless the skid is full
  assign en          = (cnt_r != 2'd2);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_ch.valid};
    end
  end

  // stage 0: capture; stage 1: hold while derived sizes settle
  always_comb begin
    s0_nxt     = '0;
    s0_nxt.idx = in_ch.element_index;
    s0_nxt.rem = in_ch.element_index;
  end

  // stage 2: range flags against the grid total
  always_comb begin
    s2_nxt      = pipe_r[1];
    s2_nxt.oor  = EW'(pipe_r[1].idx) >= EW'(total_r);
    s2_nxt.last = EW'(pipe_r[1].idx) == (EW'(total_r) - EW'(1));
  end

  assign pipe_nxt[0] = s0_nxt;
  assign pipe_nxt[1] = pipe_r[0];
  assign pipe_nxt[2] = s2_nxt;

  // index / plane, one quotient bit per stage, MSB first
  for (genvar n = 0; n < QW; n++) begin : g_div_plane
    localparam int S = 3 + n;
    localparam int B = QW - 1 - n;
    logic [CW1-1:0] num, den;
    stage_t         st_nxt;

    assign num = CW1'(pipe_r[S-1].rem);
    assign den = CW1'(plane_r) << B;

    always_comb begin
      st_nxt = pipe_r[S-1];
      if (num >= den) begin
        st_nxt.rem   = ADDR_BITS'(num - den);
        st_nxt.qi[B] = 1'b1;
      end
    end

    assign pipe_nxt[S] = st_nxt;
  end

  // remainder / row, same scheme
  for (genvar n = 0; n < QW; n++) begin : g_div_row
    localparam int S = 3 + QW + n;
    localparam int B = QW - 1 - n;
    logic [CW2-1:0] num, den;
    stage_t         st_nxt;

    assign num = CW2'(pipe_r[S-1].rem);
    assign den = CW2'(row_r) << B;

    always_comb begin
      st_nxt = pipe_r[S-1];
      if (num >= den) begin
        st_nxt.rem   = ADDR_BITS'(num - den);
        st_nxt.qj[B] = 1'b1;
      end
    end

    assign pipe_nxt[S] = st_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  // ------------------------------------------------------- multiply stage
  // address = a*P + b*Q + c, operands picked by mode (i = qi, j = qj, k = rem)
  always_comb begin
    quo_t  a, b, c, k;
    addr_t p;
    dim_t  q;
    k = QW'(pipe_r[NP-1].rem);
    case (mode_r)
      MODE_X2Y: begin
        a = pipe_r[NP-1].qj;
        p = ADDR_BITS'(xy_r);
        b = k;
        q = dx_r;
        c = pipe_r[NP-1].qi;
      end
      MODE_Y2Z: begin
        a = pipe_r[NP-1].qi;
        p = ADDR_BITS'(yz_r);
        b = k;
        q = dy_r;
        c = pipe_r[NP-1].qj;
      end
      default: begin
        a = k;
        p = ADDR_BITS'(yz_r);
        b = pipe_r[NP-1].qj;
        q = dz_r;
        c = pipe_r[NP-1].qi;
      end
    endcase
    mul_nxt.pa   = ADDR_BITS'((ADDR_BITS + QW)'(a) * (ADDR_BITS + QW)'(p));
    mul_nxt.pb   = ADDR_BITS'((QW + DW)'(b) * (QW + DW)'(q));
    mul_nxt.c    = c;
    mul_nxt.idx  = pipe_r[NP-1].idx;
    mul_nxt.last = pipe_r[NP-1].last;
    mul_nxt.oor  = pipe_r[NP-1].oor;
  end

  // ------------------------------------------------------- add stage
  always_comb begin
    addr_t perm;
    perm = mul_r.pa + mul_r.pb + ADDR_BITS'(mul_r.c);
    res_nxt.last = mul_r.last & ~mul_r.oor;
    res_nxt.oor  = mul_r.oor;
    if (mul_r.oor) begin
      res_nxt.rd = '0;
      res_nxt.wr = '0;
    end else if (mode_r == MODE_X2Z) begin
      res_nxt.rd = mul_r.idx;
      res_nxt.wr = perm;
    end else begin
      res_nxt.rd = perm;
      res_nxt.wr = mul_r.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_r <= mul_nxt;
      res_r <= res_nxt;
    end
  end

  // ------------------------------------------------------- output skid
  assign push = en & vld_r[NS-1];
  assign pop  = out_ch.valid & out_ch.ready;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = res_r;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = res_r;
        end else if (push) begin
          skid_nxt = res_r;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt  = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = skid_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: cnt_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.read_address  = head_r.rd;
  assign out_ch.write_address = head_r.wr;
  assign out_ch.last_element  = head_r.last;
  assign out_ch.out_of_range  = head_r.oor;

  // ------------------------------------------------------- checks
`ifndef SYNTHESIS
  // an index past the grid carries zero addresses and no last flag
  a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_of_range |->
      out_ch.read_address == '0 && out_ch.write_address == '0 &&
      !out_ch.last_element)
    else $error("out of range word with non-zero fields");

  // range flags are exclusive at the check stage
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] && pipe_r[2].last |-> !pipe_r[2].oor)
    else $error("last and out of range both set");

  // a finished word held by a full skid is neither lost nor altered
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en && vld_r[NS-1] |=> vld_r[NS-1] && $stable(res_r))
    else $error("stalled result changed");

  // a push into a busy head lands in the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && cnt_r == 2'd1 |=> cnt_r == 2'd2 && skid_r == $past(res_r))
    else $error("skid entry not filled");
`endif

endmodule
